[src/lpnsc_pkg.sv]
// Shared types, codes and the unit parser step for the start-code converter.
package lpnsc_pkg;

	localparam int FRAME_SIZE_BITS_DEF = 24;

	localparam int CFG_ADDR_W = 3;
	localparam logic REG_LFB_IDX = 1'b0;
	localparam logic [2:0] LFB_RESET = 3'd4;

	localparam logic [1:0] MODE_UNDECIDED = 2'd0;
	localparam logic [1:0] MODE_PASS      = 2'd1;
	localparam logic [1:0] MODE_CONVERT   = 2'd2;
	localparam logic [1:0] MODE_DROP      = 2'd3;

	localparam logic [1:0] EV_NONE = 2'd0;
	localparam logic [1:0] EV_BYTE = 2'd1;
	localparam logic [1:0] EV_SC   = 2'd2;
	localparam logic [1:0] EV_END  = 2'd3;

	localparam int EV_N     = 6;
	localparam int EV_IDX_W = 3;

	localparam logic [7:0] SC_ZERO = 8'h00;
	localparam logic [7:0] SC_ONE  = 8'h01;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
	} ev_t;

	typedef struct packed {
		logic        in_payload;
		logic        emitted;
		logic [31:0] acc;
		logic [31:0] fr;
	} parse_st_t;

	typedef struct packed {
		parse_st_t  st;
		logic       ok;
		logic [1:0] ev;
	} parse_res_t;

	localparam parse_st_t ST_CLEAR = '{in_payload: 1'b0, emitted: 1'b0, acc: 32'd0, fr: 32'd0};

	// prefix length setting: 0 acts as 1, 5..7 act as 4
	function automatic logic [2:0] prefix_len(logic [2:0] lfb);
		logic [2:0] r;
		r = lfb;
		if (lfb == 3'd0) begin
			r = 3'd1;
		end else if (lfb > 3'd4) begin
			r = 3'd4;
		end
		return r;
	endfunction

	// one byte through the unit parser; ok low means parsing stops
	function automatic parse_res_t parse_step(parse_st_t st, logic [31:0] pos,
			logic [31:0] size, logic [2:0] lsz, logic [7:0] b);
		parse_res_t r;
		r.st = st;
		r.ok = 1'b1;
		r.ev = EV_NONE;
		if (st.in_payload) begin
			r.ev = EV_BYTE;
			r.st.fr = st.fr - 32'd1;
			if (st.fr == 32'd1) begin
				r.st.in_payload = 1'b0;
			end
		end else begin
			if (st.fr == 32'd0) begin
				if ({1'b0, pos} + {30'd0, lsz} > {1'b0, size}) begin
					r.ok = 1'b0;
				end else begin
					r.st.fr = {29'd0, lsz};
					r.st.acc = 32'd0;
				end
			end
			if (r.ok) begin
				if (lsz == 3'd3) begin
					if (r.st.fr == 32'd3) begin
						r.st.acc = {24'd0, b};
					end
				end else begin
					r.st.acc = {r.st.acc[23:0], b};
				end
				r.st.fr = r.st.fr - 32'd1;
				if (r.st.fr == 32'd0) begin
					if (r.st.acc == 32'd0 ||
							{2'b0, pos} + 34'd1 + {2'b0, r.st.acc} > {2'b0, size}) begin
						r.ok = 1'b0;
					end else begin
						r.ev = EV_SC;
						r.st.in_payload = 1'b1;
						r.st.fr = r.st.acc;
						r.st.emitted = 1'b1;
					end
				end
			end
		end
		return r;
	endfunction

endpackage

[src/length_prefixed_nal_to_start_code.sv]
// Length-prefixed unit stream to start-code stream converter, top level.
// Path: a request is registered in the input register, then decoded in one pass into the result
//   buffer, from which its output bytes are sent.
// Throughput: one request per cycle while each yields at most one output byte and m_tready is high;
//   a request yielding more output bytes (start codes count four) holds the next until its last is taken.
// Reset: asynchronous, clears frame state, empties the buffers and sets length_field_bytes to 4.
module length_prefixed_nal_to_start_code #(
	parameter int FRAME_SIZE_BITS = lpnsc_pkg::FRAME_SIZE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// s_tdata: data_byte, frame_size, zero fill
	input  logic [((8+FRAME_SIZE_BITS+7)/8)*8-1:0] s_tdata,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// m_tdata: out_byte
	output logic [7:0]                         m_tdata,
	// m_tuser: has_data
	output logic                               m_tuser,
	output logic                               m_tlast,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [lpnsc_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);

	localparam int PW = FRAME_SIZE_BITS + 1;

	logic [2:0] lfb_q;

	logic                       valid_s1;
	logic [7:0]                 byte_s1;
	logic [FRAME_SIZE_BITS-1:0] size_s1;

	logic [FRAME_SIZE_BITS-1:0] pos_q;
	logic [1:0]                 mode_q;
	lpnsc_pkg::parse_st_t       st_q;
	logic [7:0]                 head_q [3];

	lpnsc_pkg::ev_t                   ev_q [lpnsc_pkg::EV_N];
	logic [lpnsc_pkg::EV_IDX_W-1:0]   cnt_q;
	logic [lpnsc_pkg::EV_IDX_W-1:0]   rd_q;
	logic [1:0]                       sub_q;

	lpnsc_pkg::ev_t                   ev_d [lpnsc_pkg::EV_N];
	logic [lpnsc_pkg::EV_IDX_W-1:0]   n_d;
	logic [1:0]                       mode_d;
	lpnsc_pkg::parse_st_t             st_d;
	lpnsc_pkg::parse_res_t            pr;
	logic [7:0]                       hb [4];
	logic [2:0]                       lsz;
	logic [31:0]                      size32;
	logic [PW-1:0]                    pos_inc;
	logic                             last;
	logic                             is_sc;

	lpnsc_pkg::ev_t cur;
	logic           out_hs;
	logic           pop_ev;
	logic           buf_free;
	logic           load;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[lpnsc_pkg::CFG_ADDR_W-1] == lpnsc_pkg::REG_LFB_IDX) ?
		{29'd0, lfb_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfb_q <= lpnsc_pkg::LFB_RESET;
		end else if (psel && penable && pwrite &&
				paddr[lpnsc_pkg::CFG_ADDR_W-1] == lpnsc_pkg::REG_LFB_IDX) begin
			lfb_q <= pwdata[2:0];
		end
	end

	// output side
	assign cur      = ev_q[rd_q];
	assign m_tvalid = (rd_q != cnt_q);
	assign out_hs   = m_tvalid && m_tready;
	assign pop_ev   = out_hs && (cur.kind != lpnsc_pkg::EV_SC || sub_q == 2'd3);
	assign buf_free = !m_tvalid || (pop_ev && (rd_q + 3'd1) == cnt_q);
	assign load     = valid_s1 && buf_free;
	assign s_tready = !valid_s1 || load;
	assign m_tuser  = (cur.kind != lpnsc_pkg::EV_END);
	assign m_tlast  = (cur.kind == lpnsc_pkg::EV_END);

	always_comb begin
		case (cur.kind)
			lpnsc_pkg::EV_BYTE: m_tdata = cur.data;
			lpnsc_pkg::EV_SC:   m_tdata = (sub_q == 2'd3) ? lpnsc_pkg::SC_ONE : lpnsc_pkg::SC_ZERO;
			default:            m_tdata = 8'h00;
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata[7:0];
			size_s1 <= s_tdata[8 +: FRAME_SIZE_BITS];
		end
	end

	// per-request decode
	assign lsz     = lpnsc_pkg::prefix_len(lfb_q);
	assign size32  = 32'(size_s1);
	assign pos_inc = {1'b0, pos_q} + PW'(1);
	assign last    = (pos_inc >= {1'b0, size_s1});
	assign hb[0]   = head_q[0];
	assign hb[1]   = head_q[1];
	assign hb[2]   = head_q[2];
	assign hb[3]   = byte_s1;
	assign is_sc   = (hb[0] == 8'h00) && (hb[1] == 8'h00) &&
		((hb[2] == 8'h00 && hb[3] == 8'h01) || hb[2] == 8'h01);

	always_comb begin
		for (int i = 0; i < lpnsc_pkg::EV_N; i++) begin
			ev_d[i] = '0;
		end
		n_d    = '0;
		mode_d = mode_q;
		st_d   = st_q;
		pr     = '0;
		case (mode_q)
			lpnsc_pkg::MODE_UNDECIDED: begin
				if (pos_q >= FRAME_SIZE_BITS'(3)) begin
					if (is_sc) begin
						for (int k = 0; k < 4; k++) begin
							ev_d[n_d] = '{kind: lpnsc_pkg::EV_BYTE, data: hb[k]};
							n_d = n_d + 3'd1;
						end
						mode_d = lpnsc_pkg::MODE_PASS;
					end else begin
						mode_d = lpnsc_pkg::MODE_CONVERT;
						st_d = lpnsc_pkg::ST_CLEAR;
						for (int k = 0; k < 4; k++) begin
							if (mode_d == lpnsc_pkg::MODE_CONVERT) begin
								pr = lpnsc_pkg::parse_step(st_d, 32'(k), size32, lsz, hb[k]);
								st_d = pr.st;
								if (pr.ev != lpnsc_pkg::EV_NONE) begin
									ev_d[n_d] = '{kind: pr.ev, data: hb[k]};
									n_d = n_d + 3'd1;
								end
								if (!pr.ok) begin
									if (!pr.st.emitted) begin
										// first unit failed: whole head behind one start code
										ev_d[n_d] = '{kind: lpnsc_pkg::EV_SC, data: 8'h00};
										n_d = n_d + 3'd1;
										for (int j = 0; j < 4; j++) begin
											ev_d[n_d] = '{kind: lpnsc_pkg::EV_BYTE, data: hb[j]};
											n_d = n_d + 3'd1;
										end
										mode_d = lpnsc_pkg::MODE_PASS;
									end else begin
										mode_d = lpnsc_pkg::MODE_DROP;
									end
								end
							end
						end
					end
				end
			end
			lpnsc_pkg::MODE_PASS: begin
				ev_d[n_d] = '{kind: lpnsc_pkg::EV_BYTE, data: byte_s1};
				n_d = n_d + 3'd1;
			end
			lpnsc_pkg::MODE_CONVERT: begin
				pr = lpnsc_pkg::parse_step(st_q, 32'(pos_q), size32, lsz, byte_s1);
				st_d = pr.st;
				if (pr.ev != lpnsc_pkg::EV_NONE) begin
					ev_d[n_d] = '{kind: pr.ev, data: byte_s1};
					n_d = n_d + 3'd1;
				end
				if (!pr.ok) begin
					mode_d = lpnsc_pkg::MODE_DROP;
				end
			end
			default: ;
		endcase
		if (last) begin
			ev_d[n_d] = '{kind: lpnsc_pkg::EV_END, data: 8'h00};
			n_d = n_d + 3'd1;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			mode_q <= lpnsc_pkg::MODE_UNDECIDED;
			st_q   <= lpnsc_pkg::ST_CLEAR;
		end else if (load) begin
			if (last) begin
				pos_q  <= '0;
				mode_q <= lpnsc_pkg::MODE_UNDECIDED;
				st_q   <= lpnsc_pkg::ST_CLEAR;
			end else begin
				pos_q  <= pos_inc[FRAME_SIZE_BITS-1:0];
				mode_q <= mode_d;
				st_q   <= st_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && mode_q == lpnsc_pkg::MODE_UNDECIDED && pos_q < FRAME_SIZE_BITS'(3)) begin
			head_q[pos_q[1:0]] <= byte_s1;
		end
	end

	// result buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= '0;
			sub_q <= 2'd0;
		end else begin
			if (load) begin
				cnt_q <= n_d;
				rd_q  <= '0;
			end else if (pop_ev) begin
				rd_q <= rd_q + 3'd1;
			end
			if (out_hs && cur.kind == lpnsc_pkg::EV_SC) begin
				sub_q <= sub_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < lpnsc_pkg::EV_N; i++) begin
				ev_q[i] <= ev_d[i];
			end
		end
	end

	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_q <= cnt_q)
		else $error("read index beyond buffer fill");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(lpnsc_pkg::EV_N))
		else $error("buffer fill beyond depth");

	a_sub_in_sc: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q != 2'd0 |-> (m_tvalid && cur.kind == lpnsc_pkg::EV_SC))
		else $error("start code phase outside a start code");

	a_head_pos: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == lpnsc_pkg::MODE_UNDECIDED |-> pos_q <= FRAME_SIZE_BITS'(3))
		else $error("undecided frame past head");

	a_payload_len: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.in_payload |-> st_q.fr != 32'd0)
		else $error("payload copy with no bytes left");

endmodule
